>>> rtl/dqe_pkg.sv
// Shared types and constants of the double-ended queue.
// Used by the storage cell, the cell row and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dqe_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int COUNT_WIDTH = 5;

   // value reported for both ends of an empty queue
   localparam logic signed [DATA_WIDTH-1:0] PEEK_EMPTY = '1;

   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   // command broadcast to every cell of one row
   typedef struct packed {
      logic shift_in;   // new entry enters at cell 0, all move one cell out
      logic shift_out;  // entry at cell 0 leaves, all move one cell in
      logic write_end;  // new entry lands in the first unused cell
   } cell_cmd_type;

   // one result item
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  front_value;
      logic signed [DATA_WIDTH-1:0]  rear_value;
      logic        [COUNT_WIDTH-1:0] entry_count;
      logic                          is_empty;
      logic                          is_full;
      logic                          op_error;
   } rsp_type;

endpackage : dqe_pkg

`default_nettype wire

>>> rtl/dqe_cell.sv
// One storage cell of a queue row: holds one entry and trades it with its neighbors.
// Depends on dqe_pkg for the row command type.
`timescale 1ns / 1ps
`default_nettype none

module dqe_cell
   import dqe_pkg::*;
(
   input  wire logic                         clock,
   input  wire cell_cmd_type                 cmd,
   input  wire logic                         at_end,
   input  wire logic signed [DATA_WIDTH-1:0] prev_value,
   input  wire logic signed [DATA_WIDTH-1:0] next_value,
   input  wire logic signed [DATA_WIDTH-1:0] push_value,
   output logic signed      [DATA_WIDTH-1:0] value
);

   logic signed [DATA_WIDTH-1:0] value_ff;
   logic signed [DATA_WIDTH-1:0] value_in;

   // shifting takes precedence; an end write only hits the cell past the last entry
   always_comb begin
      priority if (cmd.shift_in) begin
         value_in = prev_value;
      end else if (cmd.shift_out) begin
         value_in = next_value;
      end else if (cmd.write_end && at_end) begin
         value_in = push_value;
      end else begin
         value_in = value_ff;
      end
   end

   // payload only, no reset
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule : dqe_cell

`default_nettype wire

>>> rtl/dqe_row.sv
// Row of DEPTH storage cells holding the queue in order from one end.
// Depends on dqe_pkg and dqe_cell.
`timescale 1ns / 1ps
`default_nettype none

module dqe_row
   import dqe_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  wire logic                              clock,
   input  wire cell_cmd_type                      cmd,
   input  wire logic [$clog2(DEPTH+1)-1:0]        count,
   input  wire logic signed [DATA_WIDTH-1:0]      push_value,
   output logic signed      [DATA_WIDTH-1:0]      head_value,
   output logic signed      [DATA_WIDTH-1:0]      second_value
);

   localparam int CountWidth = $clog2(DEPTH + 1);

   logic signed [DATA_WIDTH-1:0] cell_value [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_WIDTH-1:0] prev_value;
      logic signed [DATA_WIDTH-1:0] next_value;
      logic                         at_end;

      // neighbor links; the outer cell keeps its own entry when the row shifts out
      if (i == 0) begin : g_first
         assign prev_value = push_value;
      end else begin : g_inner_prev
         assign prev_value = cell_value[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign next_value = cell_value[i];
      end else begin : g_inner_next
         assign next_value = cell_value[i+1];
      end

      // this cell is the first unused one
      assign at_end = (count == CountWidth'(i));

      dqe_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .at_end     (at_end),
         .prev_value (prev_value),
         .next_value (next_value),
         .push_value (push_value),
         .value      (cell_value[i])
      );
   end

   assign head_value   = cell_value[0];
   assign second_value = cell_value[1];

endmodule : dqe_row

`default_nettype wire

>>> rtl/double_ended_queue.sv
// Double-ended queue of signed 32-bit entries, top level.
// Depends on dqe_pkg, dqe_row and dqe_cell.
//
// The queue is kept twice, in two rows of DEPTH cells: one row ordered from
// the front, one from the rear, so both ends always sit in cell 0 of a row.
// A push at an end shifts that end's row by one cell and writes the far end
// of the other row; a pop shifts one row and shortens the other. One result
// item comes back per input item, registered; a second result register
// lets a new transfer be taken while the first result is stalled, and
// req_stall rises only when both hold results. No clearing pass runs after
// reset; entries are valid once pushed.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue
   import dqe_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_operation,
   input  wire logic signed [DATA_WIDTH-1:0] req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic signed [DATA_WIDTH-1:0]      rsp_front_value,
   output logic signed [DATA_WIDTH-1:0]      rsp_rear_value,
   output logic [COUNT_WIDTH-1:0]            rsp_entry_count,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic                              rsp_op_error
);

   localparam int CountWidth = $clog2(DEPTH + 1);

   op_type                       op;
   logic                         req_take;
   logic                         rsp_take;
   logic                         is_push;
   logic                         was_empty;
   logic                         was_full;
   logic                         op_ok;
   logic [CountWidth-1:0]        count_ff;
   logic [CountWidth-1:0]        count_in;
   logic [CountWidth+COUNT_WIDTH-1:0] count_wide;
   cell_cmd_type                 front_cmd;
   cell_cmd_type                 rear_cmd;
   logic signed [DATA_WIDTH-1:0] front_head;
   logic signed [DATA_WIDTH-1:0] front_second;
   logic signed [DATA_WIDTH-1:0] rear_head;
   logic signed [DATA_WIDTH-1:0] rear_second;
   rsp_type                      result;
   rsp_type                      out_ff;
   rsp_type                      out_in;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   rsp_type                      skid_ff;
   rsp_type                      skid_in;
   logic                         skid_valid_ff;
   logic                         skid_valid_in;

   assign op        = op_type'(req_operation);
   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign rsp_take  = out_valid_ff && !rsp_stall;

   // refuse a push on full and a pop on empty
   assign is_push   = (op == OP_PUSH_FRONT) || (op == OP_PUSH_REAR);
   assign was_empty = (count_ff == '0);
   assign was_full  = (count_ff == CountWidth'(DEPTH));
   assign op_ok     = is_push ? !was_full : !was_empty;

   // row commands; the row ordered from the front sees rear pushes as end writes
   always_comb begin
      front_cmd = '0;
      rear_cmd  = '0;
      if (req_take && op_ok) begin
         unique case (op)
            OP_PUSH_FRONT: begin
               front_cmd.shift_in = 1'b1;
               rear_cmd.write_end = 1'b1;
            end
            OP_PUSH_REAR: begin
               rear_cmd.shift_in   = 1'b1;
               front_cmd.write_end = 1'b1;
            end
            OP_POP_FRONT: begin
               front_cmd.shift_out = 1'b1;
            end
            OP_POP_REAR: begin
               rear_cmd.shift_out = 1'b1;
            end
            default: begin
               front_cmd = '0;
               rear_cmd  = '0;
            end
         endcase
      end
   end

   dqe_row #(.DEPTH(DEPTH)) u_front_row (
      .clock        (clock),
      .cmd          (front_cmd),
      .count        (count_ff),
      .push_value   (req_value),
      .head_value   (front_head),
      .second_value (front_second)
   );

   dqe_row #(.DEPTH(DEPTH)) u_rear_row (
      .clock        (clock),
      .cmd          (rear_cmd),
      .count        (count_ff),
      .push_value   (req_value),
      .head_value   (rear_head),
      .second_value (rear_second)
   );

   // next count
   always_comb begin
      count_in = count_ff;
      if (req_take && op_ok) begin
         count_in = is_push ? count_ff + 1'b1 : count_ff - 1'b1;
      end
   end

   // result from the state before the transfer and the operation
   always_comb begin
      result.front_value = front_head;
      result.rear_value  = rear_head;
      if (op_ok) begin
         unique case (op)
            OP_PUSH_FRONT: begin
               result.front_value = req_value;
               result.rear_value  = was_empty ? req_value : rear_head;
            end
            OP_PUSH_REAR: begin
               result.front_value = was_empty ? req_value : front_head;
               result.rear_value  = req_value;
            end
            OP_POP_FRONT: begin
               result.front_value = front_second;
            end
            OP_POP_REAR: begin
               result.rear_value = rear_second;
            end
            default: begin
               result.front_value = front_head;
               result.rear_value  = rear_head;
            end
         endcase
      end
      count_wide = {{COUNT_WIDTH{1'b0}}, count_in};
      if (count_in == '0) begin
         result.front_value = PEEK_EMPTY;
         result.rear_value  = PEEK_EMPTY;
      end
      result.entry_count = count_wide[COUNT_WIDTH-1:0];
      result.is_empty    = (count_in == '0);
      result.is_full     = (count_in == CountWidth'(DEPTH));
      result.op_error    = !op_ok;
   end

   // output register with a skid register behind it
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || rsp_take) begin
            out_in       = result;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_front_value = out_ff.front_value;
   assign rsp_rear_value  = out_ff.rear_value;
   assign rsp_entry_count = out_ff.entry_count;
   assign rsp_is_empty    = out_ff.is_empty;
   assign rsp_is_full     = out_ff.is_full;
   assign rsp_op_error    = out_ff.op_error;

endmodule : double_ended_queue

`default_nettype wire

>>> dv/tb_double_ended_queue.sv
// Self-checking testbench for double_ended_queue: random bursts of push and pop
// transfers against a queue-based prediction. Depends on dqe_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_double_ended_queue;
   import dqe_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int RANDOM_CMDS = 750;
   localparam int TAIL_CYCLES = 20;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;

   localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;

   // receiver stall behavior between long hold-offs
   typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY} rx_mode_type;
   // push/pop balance of one stretch of random commands
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   typedef struct {
      op_type                       op;
      logic signed [DATA_WIDTH-1:0] value;
      bit                           wait_idle;  // hold off until all results are back
   } deque_cmd_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [1:0]                    req_operation = OP_PUSH_FRONT;
   logic signed [DATA_WIDTH-1:0]  req_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [DATA_WIDTH-1:0]  rsp_front_value;
   logic signed [DATA_WIDTH-1:0]  rsp_rear_value;
   logic [COUNT_WIDTH-1:0]        rsp_entry_count;
   logic                          rsp_is_empty;
   logic                          rsp_is_full;
   logic                          rsp_op_error;

   deque_cmd_type                 pending_cmd_q[$];
   rsp_type                       expected_rsp_q[$];
   logic signed [DATA_WIDTH-1:0]  deque_model[$];
   int                            results_owed = 0;
   int                            fail_count = 0;
   int                            cycle_count = 0;

   double_ended_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_op_error    (rsp_op_error)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one operation to the deque copy and return the result it reports.
   function automatic rsp_type apply_deque_op(op_type op, logic signed [DATA_WIDTH-1:0] value);
      rsp_type                      r;
      r.op_error = 1'b0;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (deque_model.size() >= QUEUE_DEPTH)
               r.op_error = 1'b1;
            else if (op == OP_PUSH_FRONT)
               deque_model.push_front(value);
            else
               deque_model.push_back(value);
         end
         default: begin
            if (deque_model.size() == 0)
               r.op_error = 1'b1;
            else if (op == OP_POP_FRONT)
               void'(deque_model.pop_front());
            else
               void'(deque_model.pop_back());
         end
      endcase
      if (deque_model.size() == 0) begin
         r.front_value = PEEK_EMPTY;
         r.rear_value  = PEEK_EMPTY;
      end else begin
         r.front_value = deque_model[0];
         r.rear_value  = deque_model[deque_model.size() - 1];
      end
      r.entry_count = COUNT_WIDTH'(deque_model.size());
      r.is_empty    = (deque_model.size() == 0);
      r.is_full     = (deque_model.size() >= QUEUE_DEPTH);
      return r;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2: return PEEK_EMPTY;
         3: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic void add_cmd(op_type op, logic signed [DATA_WIDTH-1:0] value,
                                   bit wait_idle);
      deque_cmd_type c;
      c.op        = op;
      c.value     = value;
      c.wait_idle = wait_idle;
      pending_cmd_q.push_back(c);
   endfunction

   // Sender: bursts of transfers with random gaps; a wait_idle command is held
   // back until nothing is in flight.
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      deque_cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left != 0) begin
            gap_left  = gap_left - 1;
            req_valid <= 1'b0;
            req_value <= $urandom;
         end else if (pending_cmd_q.size() != 0 &&
                      (!pending_cmd_q[0].wait_idle || (!req_valid && results_owed == 0))) begin
            c = pending_cmd_q.pop_front();
            req_valid     <= 1'b1;
            req_operation <= c.op;
            req_value     <= c.value;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall pattern in stretches, plus long hold-offs that fill the block.
   int          rx_cycle  = 0;
   int          hold_left = 0;
   int          mode_left = 0;
   rx_mode_type rx_mode   = RX_FREE;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycle = rx_cycle + 1;
         if (hold_left == 0 && (rx_cycle == 300 || $urandom_range(0, 499) == 0))
            hold_left = $urandom_range(40, 90);
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               rx_mode   = rx_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(8, 64);
            end
            mode_left = mode_left - 1;
            case (rx_mode)
               RX_FREE:  rsp_stall <= 1'b0;
               RX_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
               default:  rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Monitor: predict on each accepted command, check each accepted result.
   always @(posedge clock) begin
      rsp_type seen;
      rsp_type want;
      int      delta;
      if (!reset) begin
         delta = 0;
         if (req_valid && !req_stall) begin
            expected_rsp_q.push_back(apply_deque_op(op_type'(req_operation), req_value));
            delta = delta + 1;
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_front_value, rsp_rear_value, rsp_entry_count,
                    rsp_is_empty, rsp_is_full, rsp_op_error};
            if (expected_rsp_q.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= REPORT_MAX)
                  $display("unexpected result transfer at cycle %0d", cycle_count);
            end else begin
               want  = expected_rsp_q.pop_front();
               delta = delta - 1;
               if (seen !== want) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= REPORT_MAX) begin
                     $write("mismatch at cycle %0d: exp front=%0d rear=%0d count=%0d ",
                            cycle_count, want.front_value, want.rear_value,
                            want.entry_count);
                     $write("empty=%b full=%b err=%b, ",
                            want.is_empty, want.is_full, want.op_error);
                     $display("got front=%0d rear=%0d count=%0d empty=%b full=%b err=%b",
                              seen.front_value, seen.rear_value, seen.entry_count,
                              seen.is_empty, seen.is_full, seen.op_error);
                  end
               end
            end
         end
         results_owed <= results_owed + delta;
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("double_ended_queue regression: fail");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int      phase_left;
      int      push_pct;
      bit      do_push;
      bit      at_front;
      mix_type mix;

      // errors on empty, extremes through both ends, pop back to empty
      add_cmd(OP_POP_FRONT, VAL_MAX, 1'b0);
      add_cmd(OP_POP_REAR, VAL_MIN, 1'b0);
      add_cmd(OP_PUSH_FRONT, VAL_MAX, 1'b0);
      add_cmd(OP_PUSH_REAR, VAL_MIN, 1'b0);
      add_cmd(OP_POP_FRONT, '0, 1'b0);
      add_cmd(OP_POP_REAR, '0, 1'b0);
      // fill from empty at alternating ends, then push on full
      add_cmd(OP_PUSH_REAR, PEEK_EMPTY, 1'b0);
      for (int i = 1; i < QUEUE_DEPTH; i++)
         add_cmd((i % 2) ? OP_PUSH_FRONT : OP_PUSH_REAR, pick_value(), 1'b0);
      add_cmd(OP_PUSH_FRONT, VAL_MAX, 1'b0);
      add_cmd(OP_PUSH_REAR, VAL_MIN, 1'b0);

      // random walk in stretches biased toward full, toward empty, or even
      phase_left = 0;
      mix        = MIX_EVEN;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         if (phase_left == 0) begin
            mix        = mix_type'($urandom_range(0, 2));
            phase_left = $urandom_range(10, 40);
         end
         phase_left = phase_left - 1;
         case (mix)
            MIX_FILL:  push_pct = 80;
            MIX_DRAIN: push_pct = 20;
            default:   push_pct = 50;
         endcase
         do_push  = ($urandom_range(0, 99) < push_pct);
         at_front = $urandom_range(0, 1);
         add_cmd(do_push ? (at_front ? OP_PUSH_FRONT : OP_PUSH_REAR)
                         : (at_front ? OP_POP_FRONT : OP_POP_REAR),
                 pick_value(), (n == 0) || ($urandom_range(0, 99) == 0));
      end

      do @(negedge clock); while (reset);
      do @(negedge clock); while (pending_cmd_q.size() != 0 || req_valid);
      do @(negedge clock); while (expected_rsp_q.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
      if (fail_count == 0 && expected_rsp_q.size() == 0)
         $display("double_ended_queue regression: pass");
      else
         $display("double_ended_queue regression: fail");
      $finish;
   end

endmodule

>>> filelist.f
rtl/dqe_pkg.sv
rtl/dqe_cell.sv
rtl/dqe_row.sv
rtl/double_ended_queue.sv
dv/tb_double_ended_queue.sv
